### sv/bbe_pkg.sv
// Shared types and constants for the binary boundary extraction block.
// Holds the beat structs, the register map and the window column type.
// No dependencies.
`default_nettype none

package bbe_pkg;

  localparam int GreyW      = 8;
  localparam int WidthCfgW  = 12;
  localparam int HeightCfgW = 13;
  localparam int ThreshCfgW = 8;

  localparam logic [WidthCfgW-1:0]  WidthReset     = 12'd640;
  localparam logic [HeightCfgW-1:0] HeightReset    = 13'd480;
  localparam logic [ThreshCfgW-1:0] ThresholdReset = 8'd127;

  localparam logic [GreyW-1:0] WhiteGrey = 8'd255;
  localparam logic [GreyW-1:0] BlackGrey = 8'd0;

  // Command field: a pixel beat; any other value asks for one pending output.
  localparam logic CmdPixel = 1'b0;

  localparam int ApbAddrW = 4;
  localparam int ApbDataW = 32;

  typedef enum logic [1:0] {
    RegImageWidth     = 2'd0,
    RegImageHeight    = 2'd1,
    RegBlackThreshold = 2'd2
  } bbe_reg_e;

  localparam int OutqDepth = 4;
  localparam int OutqPtrW  = $clog2(OutqDepth);
  localparam int OutqCntW  = $clog2(OutqDepth + 1);

  // One window column: bit 0 is the top row, bit 2 the newest row.
  typedef logic [2:0] bbe_col_t;

  typedef struct packed {
    logic             command;
    logic [GreyW-1:0] grey_in;
  } bbe_in_t;

  typedef struct packed {
    logic [GreyW-1:0] grey_out;
    logic             frame_end;
  } bbe_out_t;

endpackage

`default_nettype wire

### sv/bbe_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Self-contained; no package needed.
`default_nettype none

module bbe_ram #(
  parameter int Width = 1,
  parameter int Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### sv/bbe_cell.sv
// One cell of the 3x3 window chain: holds a three-row column and hands it on.
// Depends on bbe_pkg for the column type.
`default_nettype none

module bbe_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              shift_i,
  input  bbe_pkg::bbe_col_t col_i,
  output bbe_pkg::bbe_col_t col_o,
  output logic              black_o
);
  import bbe_pkg::*;

  bbe_col_t col_q, col_d;

  assign col_d = shift_i ? col_i : col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else begin
      col_q <= col_d;
    end
  end

  assign col_o   = col_q;
  assign black_o = (col_q == '0);

endmodule

`default_nettype wire

### sv/bbe_outq.sv
// Small result queue that decouples the window stage from the output channel.
// Depends on bbe_pkg for the result beat type and the queue depth.
`default_nettype none

module bbe_outq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  bbe_pkg::bbe_out_t         push_data_i,
  input  logic                      pop_ready_i,
  output logic                      valid_o,
  output bbe_pkg::bbe_out_t         data_o,
  output logic [bbe_pkg::OutqCntW-1:0] count_o
);
  import bbe_pkg::*;

  bbe_out_t            mem_q [OutqDepth];
  logic [OutqPtrW-1:0] wptr_q, wptr_d;
  logic [OutqPtrW-1:0] rptr_q, rptr_d;
  logic [OutqCntW-1:0] cnt_q, cnt_d;
  logic                pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && pop_ready_i;
  assign data_o  = mem_q[rptr_q];
  assign count_o = cnt_q;

  always_comb begin
    wptr_d = push_i ? wptr_q + OutqPtrW'(1) : wptr_q;
    rptr_d = pop ? rptr_q + OutqPtrW'(1) : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + OutqCntW'(1);
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - OutqCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

### sv/binary_boundary_extract.sv
// Binary boundary extraction, top level. Takes one beat per cycle, pixel or drain,
// while the result queue has room. A beat's result is registered in the line-store
// read stage and then in the result queue. In pixel terms an output pixel
// trails its input by image_width+1 pixel beats; drain beats release the rest.
// Reset clears control, positions and window; line-store contents are not cleared,
// a fill counter makes never-written columns read as black, so no clearing pass.
`default_nettype none

module binary_boundary_extract #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input beats
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  bbe_pkg::bbe_in_t              in_data_i,
  // Output beats
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output bbe_pkg::bbe_out_t             out_data_o,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bbe_pkg::ApbAddrW-1:0]  paddr,
  input  logic [bbe_pkg::ApbDataW-1:0]  pwdata,
  output logic [bbe_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);
  import bbe_pkg::*;

  // Column address bits, effective-width bits, row bits and effective-height bits.
  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int WdW  = $clog2(MAX_WIDTH + 1);
  localparam int RowW = $clog2(MAX_HEIGHT);
  localparam int HtW  = $clog2(MAX_HEIGHT + 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [WidthCfgW-1:0]  width_q;
  logic [HeightCfgW-1:0] height_q;
  logic [ThreshCfgW-1:0] thresh_q;
  logic                  cfg_wr;
  logic                  cfg_clear;
  bbe_reg_e              reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = bbe_reg_e'(paddr[ApbAddrW-1:2]);
  // A new image size restarts the frame; a new threshold does not.
  assign cfg_clear = cfg_wr && (reg_idx == RegImageWidth || reg_idx == RegImageHeight);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
      thresh_q <= ThresholdReset;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegImageWidth:     width_q  <= pwdata[WidthCfgW-1:0];
        RegImageHeight:    height_q <= pwdata[HeightCfgW-1:0];
        RegBlackThreshold: thresh_q <= pwdata[ThreshCfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegImageWidth:     prdata = ApbDataW'(width_q);
      RegImageHeight:    prdata = ApbDataW'(height_q);
      RegBlackThreshold: prdata = ApbDataW'(thresh_q);
      default:           prdata = '0;
    endcase
  end

  // Effective frame size: zero acts as one, oversize clamps to the maximum.
  logic [WdW-1:0] w_eff;
  logic [HtW-1:0] h_eff;

  always_comb begin
    if (width_q == '0) begin
      w_eff = WdW'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_eff = WdW'(MAX_WIDTH);
    end else begin
      w_eff = WdW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = HtW'(1);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      h_eff = HtW'(MAX_HEIGHT);
    end else begin
      h_eff = HtW'(height_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Accept stage: classify the beat, move the input and output positions and
  // work out the border and frame-end flags of the result it releases.
  // ---------------------------------------------------------------------------
  logic [ColW-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RowW-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic            done_q, done_d;

  logic in_fire, is_drain, pixel_op, drain_op, emit;
  logic in_col_last, in_row_last, out_col_last, out_row_last, out_last, out_border;
  logic pix_bit;

  assign in_fire  = in_valid_i && in_ready_o;
  assign is_drain = (in_data_i.command != CmdPixel);
  // A pixel after the frame's input is complete is dropped, and so is an early drain.
  assign pixel_op = in_fire && !is_drain && !done_q;
  assign drain_op = in_fire && is_drain && done_q;
  // Pixels release a result once the window has its first full neighbourhood.
  assign emit = drain_op ||
                (pixel_op && ((in_row_q >= RowW'(2)) ||
                              (in_row_q == RowW'(1) && in_col_q != '0)));

  assign in_col_last  = (WdW'(in_col_q) + WdW'(1)) >= w_eff;
  assign in_row_last  = (HtW'(in_row_q) + HtW'(1)) >= h_eff;
  assign out_col_last = (WdW'(out_col_q) + WdW'(1)) >= w_eff;
  assign out_row_last = (HtW'(out_row_q) + HtW'(1)) >= h_eff;
  assign out_last     = out_col_last && out_row_last;
  assign out_border   = (out_row_q == '0) || out_row_last || (out_col_q == '0) || out_col_last;
  assign pix_bit      = (in_data_i.grey_in > thresh_q);

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    done_d    = done_q;
    if (cfg_clear) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
      done_d    = 1'b0;
    end else begin
      if (pixel_op) begin
        if (in_col_last) begin
          in_col_d = '0;
          if (in_row_last) begin
            in_row_d = '0;
            done_d   = 1'b1;
          end else begin
            in_row_d = in_row_q + RowW'(1);
          end
        end else begin
          in_col_d = in_col_q + ColW'(1);
        end
      end
      if (emit) begin
        if (out_last) begin
          // Frame complete: every position returns to the start.
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
          done_d    = 1'b0;
        end else if (out_col_last) begin
          out_col_d = '0;
          out_row_d = out_row_q + RowW'(1);
        end else begin
          out_col_d = out_col_q + ColW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      done_q    <= 1'b0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      done_q    <= done_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Line stores: one RAM word per column, bit 0 is the upper line (two rows
  // back) and bit 1 the lower line (one row back). Each pixel reads its column
  // in the accept cycle and writes it back in the following cycle.
  // ---------------------------------------------------------------------------
  logic            s1_pix_q, s1_emit_q;
  logic            s1_border_q, s1_last_q, s1_bit_q, s1_known_q;
  logic [ColW-1:0] s1_addr_q;
  logic            fwd_hit_q, fwd_hit_d;
  logic [1:0]      fwd_data_q;
  logic [1:0]      ram_rdata, ram_wdata, line_bits;
  logic [WdW-1:0]  fill_q, fill_d;
  logic            known_d;

  // The beat in the second stage writes the column that the next beat may
  // read in the same cycle (only with a one-pixel row); that data is forwarded.
  assign fwd_hit_d = pixel_op && s1_pix_q && (s1_addr_q == in_col_q);
  // Columns are always first written in ascending order from zero, so the
  // written ones form a prefix; anything at or past the fill mark reads black.
  assign known_d   = (WdW'(in_col_q) < fill_q);

  assign line_bits = fwd_hit_q ? fwd_data_q : (s1_known_q ? ram_rdata : 2'b00);
  assign ram_wdata = {s1_bit_q, line_bits[1]};

  always_comb begin
    fill_d = fill_q;
    if (s1_pix_q && (WdW'(s1_addr_q) >= fill_q)) begin
      fill_d = WdW'(s1_addr_q) + WdW'(1);
    end
  end

  bbe_ram #(
    .Width (2),
    .Depth (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_pix_q),
    .waddr_i (s1_addr_q),
    .wdata_i (ram_wdata),
    .re_i    (pixel_op),
    .raddr_i (in_col_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_pix_q  <= 1'b0;
      s1_emit_q <= 1'b0;
      fwd_hit_q <= 1'b0;
      fill_q    <= '0;
    end else begin
      s1_pix_q  <= pixel_op;
      s1_emit_q <= emit;
      fwd_hit_q <= fwd_hit_d;
      fill_q    <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_border_q <= out_border;
    s1_last_q   <= out_last;
    s1_bit_q    <= pix_bit;
    s1_known_q  <= known_d;
    s1_addr_q   <= in_col_q;
    fwd_data_q  <= ram_wdata;
  end

  // ---------------------------------------------------------------------------
  // Window: a chain of three column cells, newest first. A pixel shifts its
  // binarized column in; a drain reads the window as it stands.
  // ---------------------------------------------------------------------------
  bbe_col_t new_col;
  bbe_col_t cell_col [3];
  logic     cell_black [3];

  assign new_col = {s1_bit_q, line_bits[1], line_bits[0]};

  for (genvar g = 0; g < 3; g++) begin : g_cell
    bbe_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (s1_pix_q),
      .col_i   ((g == 0) ? new_col : cell_col[(g == 0) ? 0 : g - 1]),
      .col_o   (cell_col[g]),
      .black_o (cell_black[g])
    );
  end

  // For a pixel the result uses the window after the shift: the middle column
  // is then the newest cell's content and the oldest column drops out.
  logic centre_white, all_black;
  bbe_out_t res;

  always_comb begin
    if (s1_pix_q) begin
      centre_white = cell_col[0][1];
      all_black    = (new_col == '0) && cell_black[0] && cell_black[1];
    end else begin
      centre_white = cell_col[1][1];
      all_black    = cell_black[0] && cell_black[1] && cell_black[2];
    end
    res.frame_end = s1_last_q;
    priority if (s1_border_q) begin
      res.grey_out = WhiteGrey;
    end else if (centre_white) begin
      res.grey_out = WhiteGrey;
    end else if (all_black) begin
      res.grey_out = WhiteGrey;
    end else begin
      res.grey_out = BlackGrey;
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue. A beat is taken only when the queue can hold both the
  // result still in the window stage and the one this beat may release.
  // ---------------------------------------------------------------------------
  logic [OutqCntW-1:0] outq_cnt;

  bbe_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_emit_q),
    .push_data_i (res),
    .pop_ready_i (out_ready_i),
    .valid_o     (out_valid_o),
    .data_o      (out_data_o),
    .count_o     (outq_cnt)
  );

  assign in_ready_o = (({1'b0, outq_cnt} + {{OutqCntW{1'b0}}, s1_emit_q})
                       < (OutqCntW + 1)'(OutqDepth));

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_outq_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (outq_cnt == OutqCntW'(OutqDepth)) |-> !in_ready_o)
    else $error("input taken while the result queue is full");

  a_frame_end_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && out_last) |=> (in_col_q == '0 && in_row_q == '0 && out_col_q == '0 &&
                            out_row_q == '0 && !done_q))
    else $error("positions not cleared after the last pixel of a frame");

  a_fill_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q >= $past(fill_q))
    else $error("line store fill mark moved backwards");

endmodule

`default_nettype wire
